FILE: src/alink_pkg.sv
// shared types and constants of the stop-and-wait arq link
`default_nettype none

package alink_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_HANDLE_BITS = 16;

    localparam int TIMEOUT_BITS = 16;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd5;

    // input command codes
    typedef enum logic [1:0] {
        CMD_PACKET = 2'd0,
        CMD_FRAME  = 2'd1,
        CMD_ACK    = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    // result destination codes
    typedef enum logic [1:0] {
        DEST_TX      = 2'd0,
        DEST_DELIVER = 2'd1,
        DEST_ACK     = 2'd2,
        DEST_DROP    = 2'd3
    } dest_t;

    // back end sequencing: a data frame takes two result slots
    typedef enum logic {
        BK_FIRST  = 1'b0,
        BK_SECOND = 1'b1
    } back_state_t;

    // front to back control
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } op_ctrl_t;

endpackage

`default_nettype wire

FILE: src/alink_front.sv
// front end: accepts items, decodes the command and buffers them in a two-entry queue
`default_nettype none

module alink_front import alink_pkg::*; #(
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_cmd,
    input  wire logic [HANDLE_BITS-1:0] s_pkt_id,
    output op_ctrl_t                    op_ctrl,
    output logic [HANDLE_BITS-1:0]      op_pkt_id,
    input  wire logic                   op_pop
);

    cmd_t                   cmd_q_reg [2];
    logic [HANDLE_BITS-1:0] id_q_reg  [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = op_pop && (count_reg != 2'd0);

    assign op_ctrl.valid = (count_reg != 2'd0);
    assign op_ctrl.cmd   = cmd_q_reg[rd_ptr_reg];
    assign op_pkt_id     = id_q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_q_reg[wr_ptr_reg] <= cmd_t'(s_cmd);
            id_q_reg[wr_ptr_reg]  <= s_pkt_id;
        end
    end

    // queue never holds more than two items
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("front queue count out of range");

    // pointers differ exactly when the queue holds one item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("front queue pointers inconsistent with count");

endmodule

`default_nettype wire

FILE: src/alink_back.sv
// back end: arq state, wait store, ack timer and the registered result stage
`default_nettype none

module alink_back import alink_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [TIMEOUT_BITS-1:0] timeout_ticks,
    input  wire op_ctrl_t                op_ctrl,
    input  wire logic [HANDLE_BITS-1:0]  op_pkt_id,
    output logic                         op_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_dest,
    output logic [HANDLE_BITS-1:0]       m_out_pkt_id,
    output logic                         m_last
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    logic [HANDLE_BITS-1:0]  mem [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0]  rd_data_reg;

    back_state_t             bk_state_reg, bk_state_next;
    logic                    awaiting_reg, awaiting_next;
    logic [HANDLE_BITS-1:0]  pending_reg, pending_next;
    logic [TIMEOUT_BITS-1:0] tcount_reg, tcount_next;
    logic [PW-1:0]           head_reg, head_next;
    logic [PW-1:0]           tail_reg, tail_next;
    logic [FW-1:0]           fill_reg, fill_next;

    logic                    m_valid_reg, m_valid_next;
    dest_t                   m_dest_reg, m_dest_next;
    logic [HANDLE_BITS-1:0]  m_pkt_reg, m_pkt_next;
    logic                    m_last_reg, m_last_next;

    logic                    out_free;
    logic                    go;
    logic                    load_out;
    logic                    wr_en;

    assign out_free = !m_valid_reg || m_ready;
    assign go       = op_ctrl.valid && out_free;

    assign m_valid      = m_valid_reg;
    assign m_dest       = m_dest_reg;
    assign m_out_pkt_id = m_pkt_reg;
    assign m_last       = m_last_reg;

    always_comb begin
        bk_state_next = bk_state_reg;
        awaiting_next = awaiting_reg;
        pending_next  = pending_reg;
        tcount_next   = tcount_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        op_pop        = 1'b0;
        wr_en         = 1'b0;
        load_out      = 1'b0;
        m_dest_next   = m_dest_reg;
        m_pkt_next    = m_pkt_reg;
        m_last_next   = m_last_reg;

        if (go) begin
            case (op_ctrl.cmd)
                CMD_PACKET: begin
                    op_pop = 1'b1;
                    if (!awaiting_reg) begin
                        // idle link: frame and send at once
                        awaiting_next = 1'b1;
                        pending_next  = op_pkt_id;
                        tcount_next   = timeout_ticks;
                        load_out      = 1'b1;
                        m_dest_next   = DEST_TX;
                        m_pkt_next    = op_pkt_id;
                        m_last_next   = 1'b1;
                    end else if (fill_reg == FULL_FILL) begin
                        load_out    = 1'b1;
                        m_dest_next = DEST_DROP;
                        m_pkt_next  = op_pkt_id;
                        m_last_next = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + PW'(1);
                        fill_next = fill_reg + FW'(1);
                    end
                end
                CMD_FRAME: begin
                    load_out = 1'b1;
                    if (bk_state_reg == BK_FIRST) begin
                        bk_state_next = BK_SECOND;
                        m_dest_next   = DEST_DELIVER;
                        m_pkt_next    = op_pkt_id;
                        m_last_next   = 1'b0;
                    end else begin
                        bk_state_next = BK_FIRST;
                        op_pop        = 1'b1;
                        m_dest_next   = DEST_ACK;
                        m_pkt_next    = '0;
                        m_last_next   = 1'b1;
                    end
                end
                CMD_ACK: begin
                    op_pop = 1'b1;
                    if (awaiting_reg) begin
                        if (fill_reg != '0) begin
                            // next queued handle is already in rd_data_reg
                            head_next    = (head_reg == LAST_IDX) ? '0 : head_reg + PW'(1);
                            fill_next    = fill_reg - FW'(1);
                            pending_next = rd_data_reg;
                            tcount_next  = timeout_ticks;
                            load_out     = 1'b1;
                            m_dest_next  = DEST_TX;
                            m_pkt_next   = rd_data_reg;
                            m_last_next  = 1'b1;
                        end else begin
                            awaiting_next = 1'b0;
                        end
                    end
                end
                CMD_TICK: begin
                    op_pop = 1'b1;
                    if (awaiting_reg) begin
                        // a zero load behaves as one here
                        if (tcount_reg <= TIMEOUT_BITS'(1)) begin
                            tcount_next = timeout_ticks;
                            load_out    = 1'b1;
                            m_dest_next = DEST_TX;
                            m_pkt_next  = pending_reg;
                            m_last_next = 1'b1;
                        end else begin
                            tcount_next = tcount_reg - TIMEOUT_BITS'(1);
                        end
                    end
                end
                default: begin
                    op_pop = 1'b1;
                end
            endcase
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bk_state_reg <= BK_FIRST;
            awaiting_reg <= 1'b0;
            pending_reg  <= '0;
            tcount_reg   <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            bk_state_reg <= bk_state_next;
            awaiting_reg <= awaiting_next;
            pending_reg  <= pending_next;
            tcount_reg   <= tcount_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_dest_reg <= m_dest_next;
        m_pkt_reg  <= m_pkt_next;
        m_last_reg <= m_last_next;
    end

    // wait store: read port follows the next head, write-first on a match
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= op_pkt_id;
        end
        if (wr_en && (tail_reg == head_next)) begin
            rd_data_reg <= op_pkt_id;
        end else begin
            rd_data_reg <= mem[head_next];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= FULL_FILL)
        else $error("wait store fill beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0 || fill_reg == FULL_FILL) |-> (head_reg == tail_reg))
        else $error("wait store pointers disagree with fill");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_state_reg == BK_SECOND) |-> (op_ctrl.valid && op_ctrl.cmd == CMD_FRAME))
        else $error("second result slot without a data frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && m_dest_next == DEST_DROP) |-> (awaiting_reg && fill_reg == FULL_FILL))
        else $error("drop while wait store has room");

endmodule

`default_nettype wire

FILE: src/stop_and_wait_arq_link.sv
// top level of the stop-and-wait arq link engine
// channels:
//   s_*  : input items (cmd, pkt_id) with valid/ready; cmd selects packet from upper
//          layer, data frame from lower layer, ack or timer tick
//   m_*  : result items (dest, out_pkt_id, last) with valid/ready; last marks the
//          final result of one input item
//   cfg_*: write of the ack timeout register, always ready
// result path: the first result of an item is registered into the output stage while
//   the item stands at the head of the two-entry front queue
// throughput: one item per cycle while no result waits with m_ready low; a data frame
//   holds the back end for its two result slots in the single output register
// reset: clears the link state, the timer, both queues and the output stage; the
//   timeout register returns to 5; wait store contents stay unknown and need no
//   clearing pass since only written entries are read
// stall: once a result waits with m_ready low, the result register holds and the
//   back end stops; the front queue keeps taking items until its two entries are
//   full, then s_ready drops
`default_nettype none

module stop_and_wait_arq_link import alink_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [TIMEOUT_BITS-1:0] cfg_data,
    // input item channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_cmd,
    input  wire logic [HANDLE_BITS-1:0]  s_pkt_id,
    // result item channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_dest,
    output logic [HANDLE_BITS-1:0]       m_out_pkt_id,
    output logic                         m_last
);

    // ack timeout register, picked up at the next timer load
    logic [TIMEOUT_BITS-1:0] timeout_reg, timeout_next;

    // front to back handoff
    op_ctrl_t               op_ctrl;
    logic [HANDLE_BITS-1:0] op_pkt_id;
    logic                   op_pop;

    assign cfg_ready    = 1'b1;
    assign timeout_next = (cfg_valid && cfg_ready) ? cfg_data : timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            timeout_reg <= timeout_next;
        end
    end

    // accepts and decodes items, buffers two of them
    alink_front #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_pkt_id  (s_pkt_id),
        .op_ctrl   (op_ctrl),
        .op_pkt_id (op_pkt_id),
        .op_pop    (op_pop)
    );

    // link state, wait store, timer and result register
    alink_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .timeout_ticks (timeout_reg),
        .op_ctrl       (op_ctrl),
        .op_pkt_id     (op_pkt_id),
        .op_pop        (op_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dest        (m_dest),
        .m_out_pkt_id  (m_out_pkt_id),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

FILE: sim/stop_and_wait_arq_link_test.sv
// self-checking testbench for the stop-and-wait arq link engine
module stop_and_wait_arq_link_test;
    import alink_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINK_QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    localparam int LINK_HANDLE_BITS = DEF_HANDLE_BITS;

    // run shape
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 241;
    localparam int SETTLE_CYCLES  = 16;   // front queue plus back end, with margin
    localparam int WATCHDOG_LIMIT = 500;  // cycles with no item moving on any channel
    localparam int MAX_PRINTED    = 20;

    typedef logic [LINK_HANDLE_BITS-1:0] handle_t;
    typedef logic [TIMEOUT_BITS-1:0]     ticks_t;

    // one result item as the link should emit it
    typedef struct packed {
        dest_t   dest;
        handle_t pkt;
        logic    last;
    } link_result_t;

    // mix of commands in the random traffic of one phase
    typedef enum int unsigned {
        MIX_BALANCED,
        MIX_FLOOD,
        MIX_TICKS,
        MIX_ACKS
    } traffic_mix_t;

    // tracks the link state on the side and holds the results still owed
    class arq_tracker;
        ticks_t       timeout_reg;
        logic         awaiting;
        handle_t      pending;
        ticks_t       ticks_left;
        handle_t      parked [LINK_QUEUE_DEPTH];
        int unsigned  head;
        int unsigned  tail;
        int unsigned  fill;
        link_result_t owed [$];
        int unsigned  mismatches;
        int unsigned  results_seen;
        int unsigned  resends;
        int unsigned  drops;
        int unsigned  deliveries;

        function new();
            timeout_reg  = TIMEOUT_RESET;
            awaiting     = 1'b0;
            pending      = '0;
            ticks_left   = '0;
            head         = 0;
            tail         = 0;
            fill         = 0;
            mismatches   = 0;
            results_seen = 0;
            resends      = 0;
            drops        = 0;
            deliveries   = 0;
        endfunction

        function void set_timeout(input ticks_t value);
            timeout_reg = value;
        endfunction

        function void owe(input dest_t dest, input handle_t pkt, input logic last);
            link_result_t r;
            r.dest = dest;
            r.pkt  = pkt;
            r.last = last;
            owed.insert(owed.size(), r);
        endfunction

        // frame goes out and its ack timer is loaded
        function void launch(input handle_t pkt);
            pending    = pkt;
            awaiting   = 1'b1;
            ticks_left = timeout_reg;
            owe(DEST_TX, pkt, 1'b1);
        endfunction

        function void take_item(input cmd_t cmd, input handle_t pkt);
            handle_t next;
            case (cmd)
                CMD_PACKET: begin
                    if (!awaiting) begin
                        launch(pkt);
                    end else if (fill >= LINK_QUEUE_DEPTH) begin
                        owe(DEST_DROP, pkt, 1'b1);
                        drops++;
                    end else begin
                        parked[tail] = pkt;
                        tail = (tail + 1) % LINK_QUEUE_DEPTH;
                        fill++;
                    end
                end
                CMD_FRAME: begin
                    owe(DEST_DELIVER, pkt, 1'b0);
                    owe(DEST_ACK, '0, 1'b1);
                    deliveries++;
                end
                CMD_ACK: begin
                    if (awaiting) begin
                        awaiting = 1'b0;
                        if (fill > 0) begin
                            next = parked[head];
                            head = (head + 1) % LINK_QUEUE_DEPTH;
                            fill--;
                            launch(next);
                        end
                    end
                end
                default: begin
                    if (awaiting) begin
                        if (ticks_left <= 1) begin
                            ticks_left = timeout_reg;
                            owe(DEST_TX, pending, 1'b1);
                            resends++;
                        end else begin
                            ticks_left = ticks_left - 1'b1;
                        end
                    end
                end
            endcase
        endfunction

        task flag_mismatch(input string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task match_result(input logic [1:0] dest, input handle_t pkt, input logic last);
            link_result_t want;
            results_seen++;
            if (owed.size() == 0) begin
                flag_mismatch($sformatf("unexpected result dest %0d id %h last %0d",
                                        dest, pkt, last));
            end else begin
                want = owed[0];
                owed.delete(0);
                if (dest !== want.dest)
                    flag_mismatch($sformatf("dest %0d, wanted %0d", dest, want.dest));
                if (pkt !== want.pkt)
                    flag_mismatch($sformatf("id %h, wanted %h (dest %0d)",
                                            pkt, want.pkt, want.dest));
                if (last !== want.last)
                    flag_mismatch($sformatf("last %0d, wanted %0d (dest %0d)",
                                            last, want.last, want.dest));
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn;

    logic    cfg_valid;
    logic    cfg_ready;
    ticks_t  cfg_data;

    logic    s_valid;
    logic    s_ready;
    logic [1:0] s_cmd;
    handle_t s_pkt_id;

    logic    m_valid;
    logic    m_ready;
    logic [1:0] m_dest;
    handle_t m_out_pkt_id;
    logic    m_last;

    arq_tracker  tracker = new();
    logic        feed_pauses;     // sender idles between items
    logic        drain_pauses;    // receiver stalls before each result
    int unsigned items_sent;
    int unsigned timeout_writes;
    int unsigned quiet_cycles;

    stop_and_wait_arq_link dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_pkt_id     (s_pkt_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest       (m_dest),
        .m_out_pkt_id (m_out_pkt_id),
        .m_last       (m_last)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one item; valid stays high on return so a back-to-back item keeps it up
    task automatic offer_item(input cmd_t cmd, input handle_t pkt);
        int unsigned gap;
        gap = feed_pauses ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_pkt_id <= pkt;
        do @(posedge aclk); while (!s_ready);
        tracker.take_item(cmd, pkt);
        items_sent++;
    endtask

    // random command by phase mix; handle is random even where the link ignores it
    task automatic offer_random(input traffic_mix_t mix);
        int unsigned roll;
        int unsigned to_packet;
        int unsigned to_frame;
        int unsigned to_ack;
        cmd_t        cmd;
        handle_t     pkt;
        case (mix)
            MIX_FLOOD: begin to_packet = 60; to_frame = 70; to_ack = 75; end
            MIX_TICKS: begin to_packet = 25; to_frame = 35; to_ack = 50; end
            MIX_ACKS:  begin to_packet = 35; to_frame = 50; to_ack = 90; end
            default:   begin to_packet = 30; to_frame = 45; to_ack = 70; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < to_packet)
            cmd = CMD_PACKET;
        else if (roll < to_frame)
            cmd = CMD_FRAME;
        else if (roll < to_ack)
            cmd = CMD_ACK;
        else
            cmd = CMD_TICK;
        pkt = handle_t'($urandom);
        offer_item(cmd, pkt);
    endtask

    // drop valid, wait for every owed result, then give silent items time to finish
    task automatic settle_link();
        s_valid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input ticks_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_timeout(value);
        timeout_writes++;
    endtask

    // result side: random stall before each result, none in some phases
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = drain_pauses ? $urandom_range(0, 11) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result check and watchdog on a quiet link
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.match_result(m_dest, m_out_pkt_id, m_last);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles with no item moving, %0d results owed",
                         quiet_cycles, tracker.owed.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        ticks_t       timeout;
        traffic_mix_t mix;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_cmd     <= CMD_PACKET;
        s_pkt_id  <= '0;
        feed_pauses    = 1'b1;
        drain_pauses   = 1'b1;
        items_sent     = 0;
        timeout_writes = 0;
        quiet_cycles   = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, timeout at its reset value of 5
        offer_item(CMD_TICK, 16'h1234);     // tick while idle, nothing happens
        offer_item(CMD_ACK, 16'h4321);      // stray ack while idle, ignored
        offer_item(CMD_PACKET, '1);         // idle link, sent at once
        offer_item(CMD_PACKET, '0);         // ack awaited, parked silently
        offer_item(CMD_FRAME, '1);          // delivery plus ack
        offer_item(CMD_FRAME, '0);
        repeat (5) offer_item(CMD_TICK, '0); // fifth tick expires the timer, resend
        offer_item(CMD_ACK, '0);            // ends the wait, parked packet goes out
        offer_item(CMD_ACK, '1);            // queue empty, link goes idle
        settle_link();

        // zero timeout behaves as one: resend on every tick
        write_timeout('0);
        offer_item(CMD_PACKET, 16'hA5A5);
        offer_item(CMD_TICK, 16'h5A5A);
        offer_item(CMD_TICK, '1);
        offer_item(CMD_ACK, '0);
        settle_link();

        // random phases: timeout setting, command mix and idling vary per phase
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       timeout = 16'd1;
                1:       timeout = 16'hFFFF;
                2:       timeout = '0;
                3:       timeout = 16'd4;
                4:       timeout = 16'd2;
                5:       timeout = ticks_t'($urandom_range(3, 12));
                6:       timeout = ticks_t'($urandom_range(1, 16'hFFFF));
                default: timeout = 16'd7;
            endcase
            // a new setting only reaches the timer at its next load
            write_timeout(timeout);
            mix          = traffic_mix_t'(phase % 4);
            feed_pauses  = (phase % 3 != 1);
            drain_pauses = (phase % 4 != 2);
            repeat (PHASE_ITEMS) offer_random(mix);
            settle_link();
        end

        $display("covered %0d items and %0d results over %0d timeout settings",
                 items_sent, tracker.results_seen, timeout_writes + 1);
        $display("link saw %0d deliveries, %0d resends and %0d drops on a full queue",
                 tracker.deliveries, tracker.resends, tracker.drops);
        if (tracker.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
